// ===== design/rova_pkg.sv =====
`default_nettype none

package rova_pkg;

   localparam logic [1:0] FMT_RGB24 = 2'd0;
   localparam logic [1:0] FMT_RGB32 = 2'd1;
   localparam logic [1:0] FMT_YUY2  = 2'd2;
   localparam logic [1:0] FMT_YV12  = 2'd3;

   localparam logic OP_PIXEL  = 1'b0;
   localparam logic OP_CHROMA = 1'b1;

   // bt.601 coefficients
   localparam logic [15:0] Y_R = 16'd66;
   localparam logic [15:0] Y_G = 16'd129;
   localparam logic [15:0] Y_B = 16'd25;
   localparam logic [15:0] Y_RND = 16'd128;
   localparam logic [7:0]  Y_OFS = 8'd16;
   localparam logic [15:0] C_MAIN = 16'd112;
   localparam logic [15:0] V_G = 16'd94;
   localparam logic [15:0] V_B = 16'd18;
   localparam logic [15:0] U_R = 16'd38;
   localparam logic [15:0] U_G = 16'd74;
   localparam logic [15:0] C_OFS = 16'd32896;
   localparam logic [7:0]  FULL = 8'd255;

   typedef logic [7:0] chan_type;

   typedef struct packed {
      logic [31:0] pix;
      chan_type    y;
      chan_type    u;
      chan_type    v;
   } conv_type;

   typedef struct packed {
      logic [3:0][7:0] c;
      logic [3:0][7:0] bg;
      chan_type        alpha;
      logic [3:0]      en;
      logic            did;
   } merge_type;

   typedef struct packed {
      logic ld_prod;
      logic ld_out;
   } stage_ld_type;

   // exact x / 255 for any x up to 255 * 255
   function automatic chan_type div255(input logic [15:0] x);
      logic [16:0] x1;
      logic [16:0] q;
      x1 = {1'b0, x} + 17'd1;
      q = (x1 + (x1 >> 8)) >> 8;
      return q[7:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/rova_chan_if.sv =====
`default_nettype none

interface rova_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] ovl_top_left;
   logic [31:0] ovl_top_mid;
   logic [31:0] ovl_top_right;
   logic [31:0] ovl_bot_left;
   logic [31:0] ovl_bot_mid;
   logic [31:0] ovl_bot_right;
   logic        first_column;
   logic        last_column;
   logic [31:0] bg_pixel;

   modport source (
      output valid, opcode, ovl_top_left, ovl_top_mid, ovl_top_right,
             ovl_bot_left, ovl_bot_mid, ovl_bot_right, first_column,
             last_column, bg_pixel,
      input  ready
   );
   modport sink (
      input  valid, opcode, ovl_top_left, ovl_top_mid, ovl_top_right,
             ovl_bot_left, ovl_bot_mid, ovl_bot_right, first_column,
             last_column, bg_pixel,
      output ready
   );
endinterface

interface rova_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_pixel;
   logic        blended;

   modport source (output valid, out_pixel, blended, input ready);
   modport sink (input valid, out_pixel, blended, output ready);
endinterface

`default_nettype wire

// ===== design/rgba_overlay_alpha_blender.sv =====
`default_nettype none

// channel   direction   handshake          payload
// req_port  in          valid / ready      opcode, six overlay pixels, column flags, bg_pixel
// rsp_port  out         valid / ready      out_pixel, blended
// csr_*     in          csr_wr_en          csr_wr_data = color_format
//
// one item a cycle when nothing stalls; five register stages from req_port to rsp_port
// stages: input, colour conversion lanes, filter and merge, products, divide by 255
// each stage advances on its own, so bubbles close up behind a stalled result
// reset clears the stage valid bits and color_format (rgb24)

module rgba_overlay_alpha_blender (
   input  wire logic        clock,
   input  wire logic        reset,
   rova_req_if.sink         req_port,
   rova_rsp_if.source       rsp_port,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_wr_data
);

   logic [1:0]             color_format_ff;
   logic [4:0]             vld_ff;
   logic [4:0]             vld_in;
   logic [4:0]             ld;
   logic                   accept;
   logic                   op1_ff;
   logic [31:0]            pix1_ff [6];
   logic [31:0]            pix1_in [6];
   logic [31:0]            bg1_ff;
   logic                   op2_ff;
   logic [31:0]            bg2_ff;
   logic                   did4_ff;
   logic                   did5_ff;
   rova_pkg::conv_type     lane [6];
   rova_pkg::merge_type    merged;
   rova_pkg::stage_ld_type mix_ctl;
   logic [3:0][7:0]        res;

   always_comb begin
      ld[4] = vld_ff[3] && (!vld_ff[4] || rsp_port.ready);
      ld[3] = vld_ff[2] && (!vld_ff[3] || ld[4]);
      ld[2] = vld_ff[1] && (!vld_ff[2] || ld[3]);
      ld[1] = vld_ff[0] && (!vld_ff[1] || ld[2]);
      ld[0] = req_port.valid && req_port.ready;
      vld_in[4] = ld[4] || (vld_ff[4] && !rsp_port.ready);
      vld_in[3:0] = ld[3:0] | (vld_ff[3:0] & ~ld[4:1]);
   end

   assign req_port.ready = !vld_ff[0] || ld[1];
   assign accept = ld[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         color_format_ff <= rova_pkg::FMT_RGB24;
      end else begin
         vld_ff <= vld_in;
         if (csr_wr_en) begin
            color_format_ff <= csr_wr_data;
         end
      end
   end

   // edge replication of the neighbour columns
   always_comb begin
      pix1_in[0] = req_port.first_column ? req_port.ovl_top_mid : req_port.ovl_top_left;
      pix1_in[1] = req_port.ovl_top_mid;
      pix1_in[2] = req_port.last_column ? req_port.ovl_top_mid : req_port.ovl_top_right;
      pix1_in[3] = req_port.first_column ? req_port.ovl_bot_mid : req_port.ovl_bot_left;
      pix1_in[4] = req_port.ovl_bot_mid;
      pix1_in[5] = req_port.last_column ? req_port.ovl_bot_mid : req_port.ovl_bot_right;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op1_ff <= req_port.opcode;
         bg1_ff <= req_port.bg_pixel;
         pix1_ff <= pix1_in;
      end
      if (ld[1]) begin
         op2_ff <= op1_ff;
         bg2_ff <= bg1_ff;
      end
      if (ld[3]) begin
         did4_ff <= merged.did;
      end
      if (ld[4]) begin
         did5_ff <= did4_ff;
      end
   end

   for (genvar k = 0; k < 6; k++) begin : g_conv
      rova_conv u_conv (
         .clock (clock),
         .load  (ld[1]),
         .pixel (pix1_ff[k]),
         .lane  (lane[k])
      );
   end

   rova_merge u_merge (
      .clock        (clock),
      .load         (ld[2]),
      .opcode       (op2_ff),
      .color_format (color_format_ff),
      .bg_pixel     (bg2_ff),
      .lane         (lane),
      .merged       (merged)
   );

   assign mix_ctl.ld_prod = ld[3];
   assign mix_ctl.ld_out = ld[4];

   for (genvar k = 0; k < 4; k++) begin : g_mix
      rova_mix u_mix (
         .clock (clock),
         .ctl   (mix_ctl),
         .c     (merged.c[k]),
         .s     (merged.bg[k]),
         .alpha (merged.alpha),
         .en    (merged.en[k]),
         .res   (res[k])
      );
   end

   assign rsp_port.valid = vld_ff[4];
   assign rsp_port.out_pixel = res;
   assign rsp_port.blended = did5_ff;

endmodule

`default_nettype wire

// ===== design/rova_conv.sv =====
`default_nettype none

module rova_conv (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [31:0]       pixel,
   output rova_pkg::conv_type     lane
);

   logic [7:0]         r;
   logic [7:0]         g;
   logic [7:0]         b;
   logic [15:0]        y_sum;
   logic [15:0]        u_sum;
   logic [15:0]        v_sum;
   rova_pkg::conv_type lane_in;
   rova_pkg::conv_type lane_ff;

   assign r = pixel[7:0];
   assign g = pixel[15:8];
   assign b = pixel[23:16];

   always_comb begin
      y_sum = rova_pkg::Y_R * 16'(r) + rova_pkg::Y_G * 16'(g)
            + rova_pkg::Y_B * 16'(b) + rova_pkg::Y_RND;
      // both stay within 16 bits for any input
      v_sum = rova_pkg::C_MAIN * 16'(r) + rova_pkg::C_OFS
            - rova_pkg::V_G * 16'(g) - rova_pkg::V_B * 16'(b);
      u_sum = rova_pkg::C_MAIN * 16'(b) + rova_pkg::C_OFS
            - rova_pkg::U_R * 16'(r) - rova_pkg::U_G * 16'(g);
      lane_in.pix = pixel;
      lane_in.y = y_sum[15:8] + rova_pkg::Y_OFS;
      lane_in.u = u_sum[15:8];
      lane_in.v = v_sum[15:8];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

   assign lane = lane_ff;

endmodule

`default_nettype wire

// ===== design/rova_merge.sv =====
`default_nettype none

module rova_merge (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic               opcode,
   input  wire logic [1:0]         color_format,
   input  wire logic [31:0]        bg_pixel,
   input  wire rova_pkg::conv_type lane [6],
   output rova_pkg::merge_type     merged
);

   logic                 yuv;
   logic                 two;
   logic                 any_top;
   logic                 any_bot;
   logic [7:0]           u_top;
   logic [7:0]           v_top;
   logic [7:0]           a_top;
   logic [7:0]           u_bot;
   logic [7:0]           v_bot;
   logic [7:0]           a_bot;
   logic [7:0]           u_f;
   logic [7:0]           v_f;
   logic [7:0]           a_f;
   rova_pkg::merge_type  merged_in;
   rova_pkg::merge_type  merged_ff;

   function automatic logic [7:0] tap3(input logic [7:0] l, input logic [7:0] m,
                                       input logic [7:0] r);
      logic [9:0] s;
      s = {2'b00, l} + {1'b0, m, 1'b0} + {2'b00, r};
      return s[9:2];
   endfunction

   function automatic logic [7:0] avg2(input logic [7:0] x, input logic [7:0] y);
      logic [8:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[8:1];
   endfunction

   // lanes: 0..2 top row left to right, 3..5 bottom row
   always_comb begin
      yuv = color_format inside {rova_pkg::FMT_YUY2, rova_pkg::FMT_YV12};
      two = color_format == rova_pkg::FMT_YV12;
      any_top = |{lane[0].pix[31:24], lane[1].pix[31:24], lane[2].pix[31:24]};
      any_bot = |{lane[3].pix[31:24], lane[4].pix[31:24], lane[5].pix[31:24]};
      u_top = tap3(lane[0].u, lane[1].u, lane[2].u);
      v_top = tap3(lane[0].v, lane[1].v, lane[2].v);
      a_top = tap3(lane[0].pix[31:24], lane[1].pix[31:24], lane[2].pix[31:24]);
      u_bot = tap3(lane[3].u, lane[4].u, lane[5].u);
      v_bot = tap3(lane[3].v, lane[4].v, lane[5].v);
      a_bot = tap3(lane[3].pix[31:24], lane[4].pix[31:24], lane[5].pix[31:24]);
      u_f = two ? avg2(u_top, u_bot) : u_top;
      v_f = two ? avg2(v_top, v_bot) : v_top;
      a_f = two ? avg2(a_top, a_bot) : a_top;

      merged_in.bg = bg_pixel;
      merged_in.c = '0;
      merged_in.alpha = '0;
      merged_in.en = '0;
      merged_in.did = 1'b0;
      case (opcode)
         rova_pkg::OP_PIXEL: begin
            merged_in.alpha = lane[1].pix[31:24];
            merged_in.did = lane[1].pix[31:24] != 8'd0;
            if (yuv) begin
               merged_in.c[0] = lane[1].y;
               merged_in.en = {3'b000, merged_in.did};
            end else begin
               merged_in.c[0] = lane[1].pix[23:16];
               merged_in.c[1] = lane[1].pix[15:8];
               merged_in.c[2] = lane[1].pix[7:0];
               merged_in.c[3] = lane[1].pix[31:24];
               merged_in.en = merged_in.did ?
                  {color_format == rova_pkg::FMT_RGB32, 3'b111} : 4'b0000;
            end
         end
         rova_pkg::OP_CHROMA: begin
            if (yuv && (any_top || (two && any_bot))) begin
               merged_in.did = 1'b1;
               merged_in.alpha = a_f;
               merged_in.c[0] = u_f;
               merged_in.c[1] = v_f;
               merged_in.en = 4'b0011;
            end
         end
         default: begin
            merged_in.did = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         merged_ff <= merged_in;
      end
   end

   assign merged = merged_ff;

endmodule

`default_nettype wire

// ===== design/rova_mix.sv =====
`default_nettype none

module rova_mix (
   input  wire logic                  clock,
   input  wire rova_pkg::stage_ld_type ctl,
   input  wire logic [7:0]            c,
   input  wire logic [7:0]            s,
   input  wire logic [7:0]            alpha,
   input  wire logic                  en,
   output logic [7:0]                 res
);

   logic [15:0] prod_in;
   logic [15:0] prod_ff;
   logic [7:0]  s_ff;
   logic        en_ff;
   logic [7:0]  res_in;
   logic [7:0]  res_ff;

   assign prod_in = 16'(c) * 16'(alpha) + 16'(s) * 16'(rova_pkg::FULL - alpha);
   assign res_in = en_ff ? rova_pkg::div255(prod_ff) : s_ff;

   always_ff @(posedge clock) begin
      if (ctl.ld_prod) begin
         prod_ff <= prod_in;
         s_ff <= s;
         en_ff <= en;
      end
      if (ctl.ld_out) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ===== design/rova_checker.sv =====
`default_nettype none

module rova_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] out_pixel,
   input wire logic        blended
);

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_pixel) && $stable(blended))
      else $error("stalled result changed");

   // input side only backs up when the result side is stalled
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input not ready without output stall");

   // an accepted item keeps the result side busy by the end of the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##5 rsp_valid)
      else $error("result missing after item accepted");

endmodule

bind rgba_overlay_alpha_blender rova_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .out_pixel (rsp_port.out_pixel),
   .blended   (rsp_port.blended)
);

`default_nettype wire

// ===== test/rgba_overlay_alpha_blender_tb.sv =====
`timescale 1ns / 100ps

module rgba_overlay_alpha_blender_tb;

   typedef struct packed {
      logic        opcode;
      logic [31:0] ovl_top_left;
      logic [31:0] ovl_top_mid;
      logic [31:0] ovl_top_right;
      logic [31:0] ovl_bot_left;
      logic [31:0] ovl_bot_mid;
      logic [31:0] ovl_bot_right;
      logic        first_column;
      logic        last_column;
      logic [31:0] bg_pixel;
   } overlay_item_type;

   typedef struct packed {
      logic [31:0] out_pixel;
      logic        blended;
   } blend_result_type;

   typedef struct {
      int unsigned u;
      int unsigned v;
      int unsigned a;
   } chroma_sum_type;

   class blend_tracker_type;
      logic [1:0]       fmt;
      blend_result_type pending_pixels[$];
      int               failures;

      function new();
         fmt = rova_pkg::FMT_RGB24;
         failures = 0;
      endfunction

      function void set_format(logic [1:0] f);
         fmt = f;
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      function int unsigned weigh(int unsigned c, int unsigned s, int unsigned a);
         return (c * a + s * (255 - a)) / 255;
      endfunction

      function int unsigned tap3(int unsigned l, int unsigned m, int unsigned r);
         return (l + (m << 1) + r) >> 2;
      endfunction

      function int unsigned chroma_u(logic [31:0] p);
         int unsigned t;
         t = 112 * p[23:16] + 32896 - 38 * p[7:0] - 74 * p[15:8];
         return t >> 8;
      endfunction

      function int unsigned chroma_v(logic [31:0] p);
         int unsigned t;
         t = 112 * p[7:0] + 32896 - 94 * p[15:8] - 18 * p[23:16];
         return t >> 8;
      endfunction

      function chroma_sum_type row_chroma(logic [31:0] l, logic [31:0] m, logic [31:0] r);
         chroma_sum_type s;
         s.u = tap3(chroma_u(l), chroma_u(m), chroma_u(r));
         s.v = tap3(chroma_v(l), chroma_v(m), chroma_v(r));
         s.a = tap3(l[31:24], m[31:24], r[31:24]);
         return s;
      endfunction

      function blend_result_type blend_pixel(overlay_item_type it);
         blend_result_type res;
         logic [31:0]      tm, tl, tr, bm, bl, br, bg;
         logic [7:0]       a, any;
         int unsigned      luma;
         chroma_sum_type   top, bot;
         tm = it.ovl_top_mid;
         bm = it.ovl_bot_mid;
         bg = it.bg_pixel;
         res.out_pixel = bg;
         res.blended = 1'b0;
         if (it.opcode == rova_pkg::OP_PIXEL) begin
            a = tm[31:24];
            if (a != 0) begin
               res.blended = 1'b1;
               if (fmt == rova_pkg::FMT_RGB24 || fmt == rova_pkg::FMT_RGB32) begin
                  res.out_pixel[7:0] = 8'(weigh(tm[23:16], bg[7:0], a));
                  res.out_pixel[15:8] = 8'(weigh(tm[15:8], bg[15:8], a));
                  res.out_pixel[23:16] = 8'(weigh(tm[7:0], bg[23:16], a));
                  if (fmt == rova_pkg::FMT_RGB32)
                     res.out_pixel[31:24] = 8'(weigh(a, bg[31:24], a));
               end else begin
                  luma = ((66 * tm[7:0] + 129 * tm[15:8] + 25 * tm[23:16] + 128) >> 8) + 16;
                  res.out_pixel[7:0] = 8'(weigh(luma, bg[7:0], a));
               end
            end
         end else if (fmt == rova_pkg::FMT_YUY2 || fmt == rova_pkg::FMT_YV12) begin
            tl = it.first_column ? tm : it.ovl_top_left;
            bl = it.first_column ? bm : it.ovl_bot_left;
            tr = it.last_column ? tm : it.ovl_top_right;
            br = it.last_column ? bm : it.ovl_bot_right;
            any = tl[31:24] | tm[31:24] | tr[31:24];
            if (fmt == rova_pkg::FMT_YV12)
               any = any | bl[31:24] | bm[31:24] | br[31:24];
            if (any != 0) begin
               top = row_chroma(tl, tm, tr);
               if (fmt == rova_pkg::FMT_YV12) begin
                  bot = row_chroma(bl, bm, br);
                  top.u = (top.u + bot.u) >> 1;
                  top.v = (top.v + bot.v) >> 1;
                  top.a = (top.a + bot.a) >> 1;
               end
               res.blended = 1'b1;
               res.out_pixel[7:0] = 8'(weigh(top.u, bg[7:0], top.a));
               res.out_pixel[15:8] = 8'(weigh(top.v, bg[15:8], top.a));
            end
         end
         return res;
      endfunction

      function void note_request(overlay_item_type it);
         pending_pixels.push_back(blend_pixel(it));
      endfunction

      function void check_result(logic [31:0] out_pixel, logic blended);
         blend_result_type want;
         if (pending_pixels.size() == 0) begin
            $error("result item with no request pending: out_pixel %h blended %b",
                   out_pixel, blended);
            failures++;
         end else begin
            want = pending_pixels.pop_front();
            if (out_pixel !== want.out_pixel) begin
               $error("out_pixel: expected %h, actual %h", want.out_pixel, out_pixel);
               failures++;
            end
            if (blended !== want.blended) begin
               $error("blended: expected %b, actual %b", want.blended, blended);
               failures++;
            end
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 2000;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;
   int         send_idle;
   int         recv_idle;
   int         quiet_cycles;

   blend_tracker_type tracker = new();

   rova_req_if req_bus();
   rova_rsp_if rsp_bus();

   rgba_overlay_alpha_blender dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      overlay_item_type seen;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seen.opcode = req_bus.opcode;
            seen.ovl_top_left = req_bus.ovl_top_left;
            seen.ovl_top_mid = req_bus.ovl_top_mid;
            seen.ovl_top_right = req_bus.ovl_top_right;
            seen.ovl_bot_left = req_bus.ovl_bot_left;
            seen.ovl_bot_mid = req_bus.ovl_bot_mid;
            seen.ovl_bot_right = req_bus.ovl_bot_right;
            seen.first_column = req_bus.first_column;
            seen.last_column = req_bus.last_column;
            seen.bg_pixel = req_bus.bg_pixel;
            tracker.note_request(seen);
         end
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_result(rsp_bus.out_pixel, rsp_bus.blended);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // entered and left just after a falling edge
   task automatic send_item(input overlay_item_type it);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.opcode = it.opcode;
      req_bus.ovl_top_left = it.ovl_top_left;
      req_bus.ovl_top_mid = it.ovl_top_mid;
      req_bus.ovl_top_right = it.ovl_top_right;
      req_bus.ovl_bot_left = it.ovl_bot_left;
      req_bus.ovl_bot_mid = it.ovl_bot_mid;
      req_bus.ovl_bot_right = it.ovl_bot_right;
      req_bus.first_column = it.first_column;
      req_bus.last_column = it.last_column;
      req_bus.bg_pixel = it.bg_pixel;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic op, input logic [31:0] tl, input logic [31:0] tm,
                              input logic [31:0] tr, input logic [31:0] bl,
                              input logic [31:0] bm, input logic [31:0] br,
                              input logic first, input logic last, input logic [31:0] bg);
      overlay_item_type it;
      it = '{op, tl, tm, tr, bl, bm, br, first, last, bg};
      send_item(it);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_format(input logic [1:0] f);
      wait_drained();
      csr_wr_en = 1'b1;
      csr_wr_data = f;
      tracker.set_format(f);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [31:0] random_overlay();
      logic [31:0] p;
      p = $urandom();
      case ($urandom_range(7))
         0, 1: p[31:24] = 8'h00;
         2: p[31:24] = 8'hff;
         3: p[31:24] = 8'h01;
         default: ;
      endcase
      return p;
   endfunction

   function automatic overlay_item_type random_item();
      overlay_item_type it;
      it.opcode = 1'($urandom_range(1));
      it.ovl_top_left = random_overlay();
      it.ovl_top_mid = random_overlay();
      it.ovl_top_right = random_overlay();
      it.ovl_bot_left = random_overlay();
      it.ovl_bot_mid = random_overlay();
      it.ovl_bot_right = random_overlay();
      it.first_column = ($urandom_range(3) == 0);
      it.last_column = ($urandom_range(3) == 0);
      case ($urandom_range(9))
         0: it.bg_pixel = 32'h0000_0000;
         1: it.bg_pixel = 32'hffff_ffff;
         default: it.bg_pixel = $urandom();
      endcase
      // fully transparent chroma neighbourhood
      if (it.opcode == rova_pkg::OP_CHROMA && $urandom_range(9) == 0) begin
         it.ovl_top_left[31:24] = 8'h00;
         it.ovl_top_mid[31:24] = 8'h00;
         it.ovl_top_right[31:24] = 8'h00;
         it.ovl_bot_left[31:24] = 8'h00;
         it.ovl_bot_mid[31:24] = 8'h00;
         it.ovl_bot_right[31:24] = 8'h00;
      end
      return it;
   endfunction

   initial begin
      logic [1:0] dir_fmts [4];
      logic [1:0] rnd_fmts [12];
      int         ph;
      int         f;
      int         n;
      dir_fmts = '{rova_pkg::FMT_RGB24, rova_pkg::FMT_RGB32,
                   rova_pkg::FMT_YUY2, rova_pkg::FMT_YV12};
      rnd_fmts = '{rova_pkg::FMT_RGB24, rova_pkg::FMT_RGB32, rova_pkg::FMT_YUY2,
                   rova_pkg::FMT_YV12, rova_pkg::FMT_YV12, rova_pkg::FMT_YUY2,
                   rova_pkg::FMT_RGB32, rova_pkg::FMT_RGB24, rova_pkg::FMT_YUY2,
                   rova_pkg::FMT_RGB24, rova_pkg::FMT_YV12, rova_pkg::FMT_RGB32};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = rova_pkg::FMT_RGB24;
      send_idle = 19;
      recv_idle = 82;
      rsp_bus.ready = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.opcode = rova_pkg::OP_PIXEL;
      req_bus.ovl_top_left = '0;
      req_bus.ovl_top_mid = '0;
      req_bus.ovl_top_right = '0;
      req_bus.ovl_bot_left = '0;
      req_bus.ovl_bot_mid = '0;
      req_bus.ovl_bot_right = '0;
      req_bus.first_column = 1'b0;
      req_bus.last_column = 1'b0;
      req_bus.bg_pixel = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (f = 0; f < 4; f++) begin
         write_format(dir_fmts[f]);
         // opaque white over black
         send_fields(rova_pkg::OP_PIXEL, '0, 32'hffff_ffff, '0, '0, '0, '0, 1'b0, 1'b0,
                     32'h0000_0000);
         // transparent overlay leaves background alone
         send_fields(rova_pkg::OP_PIXEL, '1, 32'h00ff_ffff, '1, '1, '1, '1, 1'b1, 1'b1,
                     32'hffff_ffff);
         send_fields(rova_pkg::OP_PIXEL, '0, 32'h0180_40c0, '0, '0, '0, '0, 1'b0, 1'b0,
                     32'h1234_5678);
         // chroma with every alpha zero
         send_fields(rova_pkg::OP_CHROMA, 32'h00ff_ffff, 32'h00ff_ffff, 32'h00ff_ffff,
                     32'h00ff_ffff, 32'h00ff_ffff, 32'h00ff_ffff, 1'b0, 1'b0, 32'hffff_ffff);
         // filtered alpha rounds to zero yet still counts as blended in the yuv formats
         send_fields(rova_pkg::OP_CHROMA, 32'h01ff_0000, 32'h0000_ff00, 32'h0000_00ff,
                     32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h8080_8080);
         // both edges replicated, only the lower row carries alpha
         send_fields(rova_pkg::OP_CHROMA, 32'hff12_3456, 32'h00ff_00ff, 32'hff65_4321,
                     32'hffff_ffff, 32'h8000_ff00, 32'hff00_0000, 1'b1, 1'b1, 32'h5a5a_a5a5);
      end

      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle = 19;
               recv_idle = 82;
            end
            1: begin
               send_idle = 82;
               recv_idle = 19;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         for (f = 0; f < 4; f++) begin
            write_format(rnd_fmts[4 * ph + f]);
            for (n = 0; n < 42; n++) begin
               if (n == 21 && f == 1)
                  wait_drained();
               send_item(random_item());
            end
         end
      end

      wait_drained();
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
